// ----- src/qpv_pkg.sv -----
// Shared types, codes and helpers for the quadrature position/velocity unit.
// Used by qpv_ctrl, qpv_datapath and the top level; no dependencies.
package qpv_pkg;

  // Input op codes
  localparam logic [1:0] OP_EDGE_A = 2'd0;
  localparam logic [1:0] OP_EDGE_B = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  // Configuration register indexes
  localparam logic REG_RAD_PER_COUNT = 1'b0;
  localparam logic REG_INTERVAL      = 1'b1;

  // Register reset values
  localparam logic [31:0] RAD_PER_COUNT_RST = 32'd102944;
  localparam logic [15:0] INTERVAL_RST      = 16'd100;

  // Velocity divider: quotient bits produced, one per cycle
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  // Datapath commands issued by the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_EDGE,
    CMD_START,
    CMD_MUL_POS,
    CMD_MUL_VEL,
    CMD_SCALE_A,
    CMD_SCALE_B,
    CMD_CHECK,
    CMD_DIV_STEP,
    CMD_ROUND
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
    logic    load_out;  // capture a result item into the output register
    logic    rec;       // recomputed flag for that item
  } dp_ctrl_t;

  typedef struct packed {
    logic due;  // update item has reached the interval
    logic ovf;  // velocity quotient does not fit in 32 bits
  } dp_stat_t;

  // Unsigned magnitude of a 32-bit two's complement value
  function automatic logic [31:0] mag32(input logic [31:0] v);
    logic [31:0] m;
    m = v[31] ? (~v + 32'd1) : v;
    return m;
  endfunction

  // Apply sign to a magnitude and clamp to the Q16.16 range
  function automatic logic [31:0] sign_sat(input logic [56:0] mag, input logic neg);
    logic [31:0] r;
    if (neg) begin
      if (mag > 57'h0_8000_0000) r = 32'h8000_0000;
      else                       r = ~mag[31:0] + 32'd1;
    end else begin
      if (mag > 57'h0_7FFF_FFFF) r = 32'h7FFF_FFFF;
      else                       r = mag[31:0];
    end
    return r;
  endfunction

endpackage

// ----- src/quadrature_position_velocity_unit.sv -----
// Quadrature x4 decoder with periodic position and velocity. Edge items (op A or B)
// step the running count and return a result in the cycle after acceptance. An update
// item whose elapsed time is below the interval, or an unused op code, also returns
// at once with recomputed 0. An update that is due recomputes position and velocity:
// one shared 32x32 multiplier pass each, x1000 scaling in S_SC1 and S_SC2, and a
// restoring divider producing one quotient bit per cycle, skipped when the quotient
// exceeds 32 bits. One item is in flight at a time; the next item is taken no earlier
// than the cycle in which the previous result is accepted. Depends on qpv_pkg, qpv_ctrl
// and qpv_datapath.
module quadrature_position_velocity_unit import qpv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic               a_level_i,
  input  logic               b_level_i,
  input  logic [31:0]        time_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] edge_count_o,
  output logic signed [31:0] position_q16_o,
  output logic signed [31:0] velocity_q16_o,
  output logic               recomputed_o
);

  dp_ctrl_t    ctrl;
  dp_stat_t    stat;
  logic [31:0] cnt_raw, pos_raw, vel_raw;

  qpv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  qpv_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .op_i           (op_i),
    .a_level_i      (a_level_i),
    .b_level_i      (b_level_i),
    .time_ms_i      (time_ms_i),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .edge_count_o   (cnt_raw),
    .position_q16_o (pos_raw),
    .velocity_q16_o (vel_raw),
    .recomputed_o   (recomputed_o)
  );

  assign edge_count_o   = $signed(cnt_raw);
  assign position_q16_o = $signed(pos_raw);
  assign velocity_q16_o = $signed(vel_raw);

`ifndef SYNTH
  // An edge item yields its result on the next cycle
  a_edge_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == OP_EDGE_A || op_i == OP_EDGE_B) |=> out_valid_o)
    else $error("edge item did not produce a result next cycle");

  // An item that is not an update never reports a recomputation
  a_no_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i != OP_UPDATE |=> !recomputed_o)
    else $error("recomputed flag set for a non-update item");

  // An edge item changes the reported count
  a_step_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == OP_EDGE_A || op_i == OP_EDGE_B) |=>
    (cnt_raw != $past(cnt_raw) || !out_valid_o))
    else $error("edge item left the count unchanged");
`endif

endmodule

// ----- src/qpv_ctrl.sv -----
// Sequencer for the quadrature unit: handshakes, command sequencing, divider count.
// Depends on qpv_pkg.
module qpv_ctrl import qpv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_stat_t   stat_i,
  output dp_ctrl_t   ctrl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MULP,
    S_MULV,
    S_SC1,
    S_SC2,
    S_CHK,
    S_DIV,
    S_ROUND,
    S_OUT
  } state_e;

  state_e              state_q;
  logic                out_valid_q;
  logic [STEP_W-1:0]   step_q;
  logic                slot_free;
  logic                accept;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && slot_free;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Command decode
  always_comb begin
    ctrl_o = '{cmd: CMD_NONE, load_out: 1'b0, rec: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_EDGE_A, OP_EDGE_B: begin
              ctrl_o.cmd      = CMD_EDGE;
              ctrl_o.load_out = 1'b1;
            end
            OP_UPDATE: begin
              if (stat_i.due) ctrl_o.cmd = CMD_START;
              else            ctrl_o.load_out = 1'b1;
            end
            default: ctrl_o.load_out = 1'b1;
          endcase
        end
      end
      S_MULP:  ctrl_o.cmd = CMD_MUL_POS;
      S_MULV:  ctrl_o.cmd = CMD_MUL_VEL;
      S_SC1:   ctrl_o.cmd = CMD_SCALE_A;
      S_SC2:   ctrl_o.cmd = CMD_SCALE_B;
      S_CHK:   ctrl_o.cmd = CMD_CHECK;
      S_DIV:   ctrl_o.cmd = CMD_DIV_STEP;
      S_ROUND: ctrl_o.cmd = CMD_ROUND;
      S_OUT: begin
        ctrl_o.load_out = slot_free;
        ctrl_o.rec      = 1'b1;
      end
      default: ctrl_o.cmd = CMD_NONE;
    endcase
  end

  // State, divider step count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_o.load_out)  out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE:  if (ctrl_o.cmd == CMD_START) state_q <= S_MULP;
        S_MULP:  state_q <= S_MULV;
        S_MULV:  state_q <= S_SC1;
        S_SC1:   state_q <= S_SC2;
        S_SC2:   state_q <= S_CHK;
        S_CHK: begin
          step_q  <= '0;
          state_q <= stat_i.ovf ? S_ROUND : S_DIV;
        end
        S_DIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(DIV_STEPS - 1)) state_q <= S_ROUND;
        end
        S_ROUND: state_q <= S_OUT;
        S_OUT:   if (slot_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/qpv_datapath.sv -----
// Datapath: count, config registers, shared multiplier, x1000 scaling,
// restoring divider, rounding/saturation and the output register. Depends on qpv_pkg.
module qpv_datapath import qpv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic [1:0]  op_i,
  input  logic        a_level_i,
  input  logic        b_level_i,
  input  logic [31:0] time_ms_i,
  input  dp_ctrl_t    ctrl_i,
  output dp_stat_t    stat_o,
  output logic [31:0] edge_count_o,
  output logic [31:0] position_q16_o,
  output logic [31:0] velocity_q16_o,
  output logic        recomputed_o
);

  // Architectural state
  logic [31:0] rpc_q, cnt_q, cnt_d, cnt_last_q, t_last_q, pos_q, vel_q;
  logic [15:0] intv_q;
  // Work registers
  logic [31:0] now_q, dmag_q, quo_q, lo_q;
  logic        vneg_q, ovf_q;
  logic [39:0] den_q, rem_q;
  logic [63:0] prod_q;
  logic [73:0] n_q;
  // Output register
  logic [31:0] out_cnt_q, out_pos_q, out_vel_q;
  logic        out_rec_q;

  logic [31:0] elapsed, delta, mul_a;
  logic [15:0] limit;
  logic        step_up;
  logic [63:0] prod_full;
  logic [56:0] pos_round, vel_mag;
  logic [40:0] trial;
  logic        trial_ge, rnd;
  logic [32:0] total;

  // Interval check for update items; zero interval acts as one
  assign elapsed    = time_ms_i - t_last_q;
  assign limit      = (intv_q == 16'd0) ? 16'd1 : intv_q;
  assign stat_o.due = elapsed >= {16'd0, limit};
  assign stat_o.ovf = n_q[73:32] >= {2'b00, den_q};

  // x4 direction
  assign step_up = (op_i == OP_EDGE_A) ? (a_level_i != b_level_i) : (a_level_i == b_level_i);
  assign cnt_d   = (ctrl_i.cmd == CMD_EDGE) ? (step_up ? cnt_q + 32'd1 : cnt_q - 32'd1) : cnt_q;
  assign delta   = cnt_q - cnt_last_q;

  // Shared 32x32 multiplier
  assign mul_a     = (ctrl_i.cmd == CMD_MUL_POS) ? mag32(cnt_q) : dmag_q;
  assign prod_full = 64'(mul_a) * 64'(rpc_q);

  // Position rounding from Q8.24 * count to Q16.16
  assign pos_round = {1'b0, prod_q[63:8]} + 57'(prod_q[7]);

  // Divider step and final rounding
  assign trial    = {rem_q, lo_q[31]};
  assign trial_ge = trial >= {1'b0, den_q};
  assign rnd      = {rem_q, 1'b0} >= {1'b0, den_q};
  assign total    = {1'b0, quo_q} + 33'(rnd);
  assign vel_mag  = ovf_q ? '1 : 57'(total);

  // Config and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpc_q      <= RAD_PER_COUNT_RST;
      intv_q     <= INTERVAL_RST;
      cnt_q      <= '0;
      cnt_last_q <= '0;
      t_last_q   <= '0;
      pos_q      <= '0;
      vel_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RAD_PER_COUNT: rpc_q  <= cfg_wdata_i;
          REG_INTERVAL:      intv_q <= cfg_wdata_i[15:0];
          default:           rpc_q  <= rpc_q;
        endcase
      end
      cnt_q <= cnt_d;
      if (ctrl_i.cmd == CMD_MUL_VEL) pos_q <= sign_sat(pos_round, cnt_q[31]);
      if (ctrl_i.cmd == CMD_ROUND) begin
        vel_q      <= sign_sat(vel_mag, vneg_q);
        cnt_last_q <= cnt_q;
        t_last_q   <= now_q;
      end
    end
  end

  // Work registers for the velocity computation
  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CMD_START: begin
        now_q  <= time_ms_i;
        den_q  <= {elapsed, 8'd0};
        dmag_q <= mag32(delta);
        vneg_q <= delta[31];
      end
      CMD_MUL_POS, CMD_MUL_VEL: prod_q <= prod_full;
      // times 1000 = 1024 - 8 - 16
      CMD_SCALE_A: n_q <= {prod_q, 10'd0} - {7'd0, prod_q, 3'd0};
      CMD_SCALE_B: n_q <= n_q - {6'd0, prod_q, 4'd0};
      CMD_CHECK: begin
        ovf_q <= stat_o.ovf;
        rem_q <= n_q[71:32];
        lo_q  <= n_q[31:0];
        quo_q <= '0;
      end
      CMD_DIV_STEP: begin
        rem_q <= trial_ge ? 40'(trial - {1'b0, den_q}) : trial[39:0];
        quo_q <= {quo_q[30:0], trial_ge};
        lo_q  <= {lo_q[30:0], 1'b0};
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= '0;
      out_pos_q <= '0;
      out_vel_q <= '0;
      out_rec_q <= 1'b0;
    end else if (ctrl_i.load_out) begin
      out_cnt_q <= cnt_d;
      out_pos_q <= pos_q;
      out_vel_q <= vel_q;
      out_rec_q <= ctrl_i.rec;
    end
  end

  assign edge_count_o   = out_cnt_q;
  assign position_q16_o = out_pos_q;
  assign velocity_q16_o = out_vel_q;
  assign recomputed_o   = out_rec_q;

endmodule

// ----- dv/tb_quadrature_position_velocity_unit.sv -----
// Self-checking testbench for quadrature_position_velocity_unit: an in-bench predictor
// of the decoder, directed and random item streams, random source idling and sink stalls.
// Depends on qpv_pkg and the RTL under src/.
module tb_quadrature_position_velocity_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import qpv_pkg::*;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int         QUIET_LIMIT   = 1000;
  localparam int         RANDOM_PHASES = 8;
  localparam int         PHASE_ITEMS   = 52;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] pos;
    logic [31:0] vel;
    logic        rec;
  } reading_t;

  // DUT ports
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic               cfg_idx_i   = REG_RAD_PER_COUNT;
  logic [31:0]        cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [1:0]         op_i        = OP_EDGE_A;
  logic               a_level_i   = 1'b0;
  logic               b_level_i   = 1'b0;
  logic [31:0]        time_ms_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] edge_count_o;
  logic signed [31:0] position_q16_o;
  logic signed [31:0] velocity_q16_o;
  logic               recomputed_o;

  // Predicted decoder state and registers
  logic [31:0] rad_q24    = RAD_PER_COUNT_RST;
  logic [15:0] interval_q = INTERVAL_RST;
  logic [31:0] count_q    = '0;
  logic [31:0] count_fix  = '0;
  logic [31:0] time_fix   = '0;
  logic [31:0] pos_hold   = '0;
  logic [31:0] vel_hold   = '0;

  reading_t awaited_readings[$];

  // Stimulus knobs and bookkeeping
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          mismatches     = 0;
  int          quiet_cycles   = 0;
  logic        enc_a          = 1'b0;
  logic        enc_b          = 1'b0;
  logic [31:0] stamp          = '0;

  quadrature_position_velocity_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .a_level_i     (a_level_i),
    .b_level_i     (b_level_i),
    .time_ms_i     (time_ms_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .edge_count_o  (edge_count_o),
    .position_q16_o(position_q16_o),
    .velocity_q16_o(velocity_q16_o),
    .recomputed_o  (recomputed_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // Sign a rounded magnitude and clamp it to Q16.16
  function automatic logic [31:0] clamp_q16(logic [63:0] mag, logic neg);
    if (neg) return (mag > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  // count * rad (Q8.24) -> Q16.16, round half away from zero on the magnitude
  function automatic logic [31:0] position_of(logic [31:0] cnt);
    logic [63:0] prod;
    prod = {32'd0, abs32(cnt)} * {32'd0, rad_q24};
    return clamp_q16((prod >> 8) + ((prod >> 7) & 64'd1), cnt[31]);
  endfunction

  // delta * rad * 1000 / elapsed -> Q16.16, long division in two steps
  function automatic logic [31:0] velocity_of(logic [31:0] delta, logic [31:0] elapsed);
    logic [63:0] prod, den, q1, r1, t, q2, r2, total;
    prod = {32'd0, abs32(delta)} * {32'd0, rad_q24};
    den  = {24'd0, elapsed, 8'd0};
    q1   = prod / den;
    r1   = prod % den;
    if (q1 > 64'hFFFF_FFFF) begin
      total = 64'hFF_FFFF_FFFF;
    end else begin
      t     = r1 * 64'd1000;
      q2    = t / den;
      r2    = t % den;
      total = q1 * 64'd1000 + q2;
      if (r2 >= den - r2) total = total + 64'd1;
    end
    return clamp_q16(total, delta[31]);
  endfunction

  // Advance the predicted state by one item and return the expected result
  function automatic reading_t decode_item(logic [1:0] op, logic a, logic b, logic [31:0] now);
    logic [31:0] elapsed, lim;
    reading_t    r;
    r.rec = 1'b0;
    case (op)
      OP_EDGE_A: count_q = (a != b) ? count_q + 32'd1 : count_q - 32'd1;
      OP_EDGE_B: count_q = (a == b) ? count_q + 32'd1 : count_q - 32'd1;
      OP_UPDATE: begin
        elapsed = now - time_fix;
        lim     = (interval_q == 16'd0) ? 32'd1 : {16'd0, interval_q};
        if (elapsed >= lim) begin
          pos_hold  = position_of(count_q);
          vel_hold  = velocity_of(count_q - count_fix, elapsed);
          count_fix = count_q;
          time_fix  = now;
          r.rec     = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = count_q;
    r.pos   = pos_hold;
    r.vel   = vel_hold;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and sink stalls
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    reading_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_readings.size() == 0) begin
        $error("result item with no pending expectation");
        mismatches++;
      end else begin
        want = awaited_readings.pop_front();
        check_field("edge_count", want.count, edge_count_o);
        check_field("position_q16", want.pos, position_q16_o);
        check_field("velocity_q16", want.vel, velocity_q16_o);
        check_field("recomputed", {31'd0, want.rec}, {31'd0, recomputed_o});
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving helpers
  // ---------------------------------------------------------------------------

  task automatic set_idle(idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 51 : (mode == IDLE_BOTH) ? 37 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 51 : (mode == IDLE_BOTH) ? 37 : 0;
  endtask

  // Present one item, hold it until accepted, then record its expected result
  task automatic send_item(logic [1:0] op, logic a, logic b, logic [31:0] now);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    a_level_i  <= a;
    b_level_i  <= b;
    time_ms_i  <= now;
    do @(posedge clk_i); while (!in_ready_o);
    awaited_readings.push_back(decode_item(op, a, b, now));
  endtask

  // One legal quadrature step in the given direction
  task automatic send_step(logic up);
    if (((~enc_a) != enc_b) == up) begin
      enc_a = ~enc_a;
      send_item(OP_EDGE_A, enc_a, enc_b, $urandom);
    end else begin
      enc_b = ~enc_b;
      send_item(OP_EDGE_B, enc_a, enc_b, $urandom);
    end
  endtask

  task automatic send_update(logic [31:0] now);
    send_item(OP_UPDATE, 1'($urandom_range(1)), 1'($urandom_range(1)), now);
  endtask

  // Stop sending and wait for every pending result
  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited_readings.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write both registers back to back while the unit is idle
  task automatic configure(logic [31:0] rad, logic [31:0] ivl_word);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_RAD_PER_COUNT;
    cfg_wdata_i <= rad;
    @(posedge clk_i);
    cfg_idx_i   <= REG_INTERVAL;
    cfg_wdata_i <= ivl_word;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    rad_q24    = rad;
    interval_q = ivl_word[15:0];
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every channel and level combination, count direction per edge
  task automatic test_edge_directions();
    for (int k = 0; k < 8; k++) begin
      send_item((k < 4) ? OP_EDGE_A : OP_EDGE_B, k[1], k[0], $urandom);
    end
  endtask

  task automatic test_unused_op();
    send_item(OP_UNUSED, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_item(OP_UNUSED, 1'b0, 1'b1, 32'h0);
  endtask

  // Interval boundary, both signs, and elapsed time across the 32-bit wrap
  task automatic test_update_timing();
    send_update(32'd99);
    repeat (3) send_step(1'b1);
    send_update(32'd99);
    send_update(32'd100);
    repeat (5) send_step(1'b0);
    send_update(32'd199);
    send_update(32'd200);
    send_update(32'hFFFF_FFF0);
    send_update(32'h0000_0054);
  endtask

  // Interval of zero behaves as one; upper data bits are dropped
  task automatic test_zero_interval();
    configure(32'h0100_0000, 32'hABCD_0000);
    stamp = $urandom;
    send_update(stamp);
    send_step(1'b1);
    send_update(stamp);
    send_update(stamp + 32'd1);
  endtask

  // Largest scale: saturating position, and velocity beyond the divider range
  task automatic test_saturation();
    set_idle(IDLE_BOTH);
    configure(32'hFFFF_FFFF, 32'd1);
    while (count_q != 32'd0) send_step(count_q[31]);
    stamp = $urandom;
    send_update(stamp);
    repeat (257) send_step(1'b1);
    stamp = stamp + 32'd1;
    send_update(stamp);
    repeat (257) send_step(1'b0);
    stamp = stamp + 32'd1;
    send_update(stamp);
    // count of -128 lands exactly on the negative limit, -129 goes past it
    repeat (128) send_step(1'b0);
    stamp = stamp + 32'd1;
    send_update(stamp);
    send_step(1'b0);
    stamp = stamp + 32'd1;
    send_update(stamp);
  endtask

  // Mostly legal quadrature bursts and periodic updates, some noise items
  task automatic test_random_traffic();
    int          sent, burst, span;
    logic        up;
    logic [31:0] rad, ivl;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_idle(idle_mode_e'(phase % 4));
      case (phase)
        0:       begin rad = RAD_PER_COUNT_RST; ivl = INTERVAL_RST; end
        1:       begin rad = 32'hFFFF_FFFF; ivl = 32'd1; end
        2:       begin rad = 32'd1; ivl = {16'($urandom), 16'hFFFF}; end
        3:       begin rad = $urandom; ivl = $urandom_range(1, 65535); end
        4:       begin rad = 32'h0100_0000; ivl = 32'd0; end
        5:       begin rad = $urandom_range(1, 1 << 20); ivl = $urandom_range(1, 200); end
        6:       begin rad = $urandom; ivl = $urandom_range(1, 20); end
        default: begin rad = RAD_PER_COUNT_RST; ivl = INTERVAL_RST; end
      endcase
      configure(rad, ivl);
      span  = (interval_q == 16'd0) ? 1 : int'(interval_q);
      stamp = (phase == 2) ? 32'hFFFF_FFFF - $urandom_range(200000) : $urandom;
      sent  = 0;
      up    = 1'b1;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(99)) inside
          [0:9]: begin
            // noise: any op code, random levels that can break the Gray sequence
            send_item(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      $urandom);
            sent++;
          end
          [10:27]: begin
            if ($urandom_range(9) == 0) stamp = $urandom;
            else                        stamp = stamp + $urandom_range(0, 2 * span);
            send_update(stamp);
            sent++;
          end
          default: begin
            if ($urandom_range(9) < 3) up = ~up;
            burst = ($urandom_range(4) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 12);
            repeat (burst) send_step(up);
            sent += burst;
          end
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    set_idle(IDLE_NONE);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_directions();
    test_unused_op();
    test_update_timing();
    test_zero_interval();
    test_saturation();
    test_random_traffic();

    // drain, then leave room for any stray result past the longest latency
    settle();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && awaited_readings.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
